/* src/wes_pkg.sv */
// Shared constants, reset values and handshake types for the wave extrema statistics block.
package wes_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CNT_W     = 32;
  localparam int VAL_W     = 32;
  localparam int AMP_W     = 32;
  localparam int TIME_W    = 32;
  localparam int IVL_FRAC  = 8;
  localparam int MEAN_W    = TIME_W + IVL_FRAC;
  localparam int TOTAL_W   = 32;
  localparam int PROD_W    = MEAN_W + CNT_W + 1;
  localparam int STEP_W    = $clog2(MEAN_W + 1);

  localparam longint RST_MAG = longint'(9999) * (longint'(1) << FRAC_BITS);

  function automatic logic [VAL_W-1:0] sat_s32(input longint v);
    logic [VAL_W-1:0] r;
    if (v > longint'(32'h7FFF_FFFF)) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -longint'(64'h8000_0000)) begin
      r = 32'h8000_0000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [AMP_W-1:0] sat_u32(input longint v);
    logic [AMP_W-1:0] r;
    if (v > longint'(64'hFFFF_FFFF)) begin
      r = '1;
    end else begin
      r = v[AMP_W-1:0];
    end
    return r;
  endfunction

  localparam logic [VAL_W-1:0] HIGH_RST    = sat_s32(-RST_MAG);
  localparam logic [VAL_W-1:0] LOW_RST     = sat_s32(RST_MAG);
  localparam logic [AMP_W-1:0] AMP_LOW_RST = sat_u32(RST_MAG);

  // Request to the running mean unit: floor((mean * count + addend) / (count + 1)).
  typedef struct packed {
    logic              start;
    logic [MEAN_W-1:0] mean;
    logic [CNT_W-1:0]  count;
    logic [MEAN_W-1:0] addend;
  } wes_req_t;

  typedef struct packed {
    logic              done;
    logic [MEAN_W-1:0] quotient;
  } wes_rsp_t;

endpackage

/* src/wes_mean_unit.sv */
// Iterative running mean unit: shift-add multiply, one add, then restoring division.
module wes_mean_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  wes_pkg::wes_req_t req,
  output wes_pkg::wes_rsp_t rsp
);
  import wes_pkg::*;

  typedef enum logic [4:0] {
    U_IDLE = 5'b00001,
    U_MUL  = 5'b00010,
    U_ADD  = 5'b00100,
    U_DIV  = 5'b01000,
    U_DONE = 5'b10000
  } ustate_t;

  ustate_t             st_r, st_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [MEAN_W-1:0]   mcand_r, mcand_nxt;
  logic [CNT_W-1:0]    mplier_r, mplier_nxt;
  logic [CNT_W:0]      divisor_r, divisor_nxt;
  logic [MEAN_W-1:0]   addend_r, addend_nxt;
  logic [PROD_W-1:0]   p_r, p_nxt;

  logic [CNT_W+1:0]    trial;
  logic [CNT_W:0]      rem;

  assign rem   = p_r[PROD_W-1:MEAN_W];
  assign trial = {rem, p_r[MEAN_W-1]} - {1'b0, divisor_r};

  always_comb begin
    st_nxt      = st_r;
    step_nxt    = step_r;
    mcand_nxt   = mcand_r;
    mplier_nxt  = mplier_r;
    divisor_nxt = divisor_r;
    addend_nxt  = addend_r;
    p_nxt       = p_r;
    unique case (st_r)
      U_IDLE, U_DONE: begin
        if (req.start) begin
          mcand_nxt   = req.mean;
          mplier_nxt  = req.count;
          divisor_nxt = {1'b0, req.count} + {{CNT_W{1'b0}}, 1'b1};
          addend_nxt  = req.addend;
          p_nxt       = '0;
          step_nxt    = STEP_W'(CNT_W - 1);
          st_nxt      = U_MUL;
        end else begin
          st_nxt = U_IDLE;
        end
      end
      U_MUL: begin
        // Most significant multiplier bit first.
        p_nxt = {p_r[PROD_W-2:0], 1'b0}
              + (mplier_r[CNT_W-1] ? {{(PROD_W-MEAN_W){1'b0}}, mcand_r} : '0);
        mplier_nxt = {mplier_r[CNT_W-2:0], 1'b0};
        if (step_r == '0) begin
          st_nxt = U_ADD;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      U_ADD: begin
        p_nxt    = p_r + {{(PROD_W-MEAN_W){1'b0}}, addend_r};
        step_nxt = STEP_W'(MEAN_W - 1);
        st_nxt   = U_DIV;
      end
      U_DIV: begin
        // The upper part holds the partial remainder, which stays below the divisor.
        if (!trial[CNT_W+1]) begin
          p_nxt = {trial[CNT_W:0], p_r[MEAN_W-2:0], 1'b1};
        end else begin
          p_nxt = {rem[CNT_W-1:0], p_r[MEAN_W-1:0], 1'b0};
        end
        if (step_r == '0) begin
          st_nxt = U_DONE;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      default: st_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= U_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    step_r    <= step_nxt;
    mcand_r   <= mcand_nxt;
    mplier_r  <= mplier_nxt;
    divisor_r <= divisor_nxt;
    addend_r  <= addend_nxt;
    p_r       <= p_nxt;
  end

  assign rsp.done     = (st_r == U_DONE);
  assign rsp.quotient = p_r[MEAN_W-1:0];

endmodule

/* src/wave_extrema_statistics_core.sv */
// Top level of the wave extrema statistics block: statistics registers, sequencer and output stage.
// Input: an extremum that follows another of the same measurement holds the input while it passes
// twice through the shared running mean unit (32 multiply steps, one add, 40 divide steps, done);
// a first extremum only updates the bookkeeping and does not stall. A finish goes to S_EMIT; once
// the output stage is free its record is registered onto out_valid and the sequencer returns to idle.
// Synchronous active-low reset clears statistics and out_valid.
module wave_extrema_statistics_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_mode,
  input  logic signed [wes_pkg::VAL_W-1:0] in_sample_value,
  input  logic [wes_pkg::TIME_W-1:0]       in_time_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [wes_pkg::VAL_W-1:0] out_peak_high,
  output logic signed [wes_pkg::VAL_W-1:0] out_peak_low,
  output logic [wes_pkg::AMP_W-1:0]        out_mean_amplitude,
  output logic [wes_pkg::AMP_W-1:0]        out_largest_amplitude,
  output logic [wes_pkg::AMP_W-1:0]        out_smallest_amplitude,
  output logic [wes_pkg::MEAN_W-1:0]       out_mean_interval,
  output logic [wes_pkg::TOTAL_W-1:0]      out_wave_total,
  output logic [wes_pkg::TIME_W-1:0]       out_finish_time
);
  import wes_pkg::*;

  // The sequencer walks one extremum through two passes of the mean unit: amplitude
  // first, then interval. A finish command waits in S_EMIT until the output stage is free.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_AMP  = 4'b0010,
    S_INT  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                   st_r, st_nxt;

  // Measurement state.
  logic                     seen_any_r, seen_any_nxt;
  logic                     toggle_r, toggle_nxt;
  logic                     inc_pend_r, inc_pend_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic signed [VAL_W-1:0]  prev_value_r, prev_value_nxt;
  logic [TIME_W-1:0]        prev_time_r, prev_time_nxt;
  logic signed [VAL_W-1:0]  high_r, high_nxt;
  logic signed [VAL_W-1:0]  low_r, low_nxt;
  logic [AMP_W-1:0]         amp_mean_r, amp_mean_nxt;
  logic [AMP_W-1:0]         amp_high_r, amp_high_nxt;
  logic [AMP_W-1:0]         amp_low_r, amp_low_nxt;
  logic [MEAN_W-1:0]        ivl_mean_r, ivl_mean_nxt;
  logic [TIME_W-1:0]        dt_r, dt_nxt;
  logic [TIME_W-1:0]        fin_time_r, fin_time_nxt;

  // Output stage.
  logic                     out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0]  o_high_r, o_high_nxt;
  logic signed [VAL_W-1:0]  o_low_r, o_low_nxt;
  logic [AMP_W-1:0]         o_amp_mean_r, o_amp_mean_nxt;
  logic [AMP_W-1:0]         o_amp_high_r, o_amp_high_nxt;
  logic [AMP_W-1:0]         o_amp_low_r, o_amp_low_nxt;
  logic [MEAN_W-1:0]        o_ivl_mean_r, o_ivl_mean_nxt;
  logic [TOTAL_W-1:0]       o_total_r, o_total_nxt;
  logic [TIME_W-1:0]        o_fin_r, o_fin_nxt;

  logic                     in_xfer;
  logic signed [VAL_W:0]    diff;
  logic [VAL_W:0]           diff_abs;
  logic [AMP_W-1:0]         amp;
  logic                     out_free;
  wes_req_t                 req;
  wes_rsp_t                 rsp;

  wes_mean_unit u_mean (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Items are taken only while the sequencer is idle.
  assign in_stall = (st_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // The difference of two signed 32-bit values always fits 32 unsigned bits once its
  // sign is removed, so the saturation of the amplitude never bites.
  assign diff     = {prev_value_r[VAL_W-1], prev_value_r}
                  - {in_sample_value[VAL_W-1], in_sample_value};
  assign diff_abs = diff[VAL_W] ? (~diff + 1'b1) : diff;
  assign amp      = diff_abs[VAL_W] ? '1 : diff_abs[AMP_W-1:0];

  always_comb begin
    st_nxt         = st_r;
    seen_any_nxt   = seen_any_r;
    toggle_nxt     = toggle_r;
    inc_pend_nxt   = inc_pend_r;
    count_nxt      = count_r;
    prev_value_nxt = prev_value_r;
    prev_time_nxt  = prev_time_r;
    high_nxt       = high_r;
    low_nxt        = low_r;
    amp_mean_nxt   = amp_mean_r;
    amp_high_nxt   = amp_high_r;
    amp_low_nxt    = amp_low_r;
    ivl_mean_nxt   = ivl_mean_r;
    dt_nxt         = dt_r;
    fin_time_nxt   = fin_time_r;

    out_valid_nxt  = out_valid_r && out_stall;
    o_high_nxt     = o_high_r;
    o_low_nxt      = o_low_r;
    o_amp_mean_nxt = o_amp_mean_r;
    o_amp_high_nxt = o_amp_high_r;
    o_amp_low_nxt  = o_amp_low_r;
    o_ivl_mean_nxt = o_ivl_mean_r;
    o_total_nxt    = o_total_r;
    o_fin_nxt      = o_fin_r;

    req.start  = 1'b0;
    req.count  = count_r;
    req.mean   = {{(MEAN_W-AMP_W){1'b0}}, amp_mean_r};
    req.addend = {{(MEAN_W-AMP_W){1'b0}}, amp};

    unique case (st_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_mode) begin
            fin_time_nxt = in_time_ms;
            st_nxt       = S_EMIT;
          end else begin
            // Bookkeeping common to every extremum. The wave counter step is held
            // back while the means still need the old count.
            seen_any_nxt   = 1'b1;
            toggle_nxt     = !toggle_r;
            prev_value_nxt = in_sample_value;
            prev_time_nxt  = in_time_ms;
            if (seen_any_r) begin
              if (in_sample_value > high_r) high_nxt = in_sample_value;
              if (in_sample_value < low_r)  low_nxt  = in_sample_value;
              if (amp > amp_high_r) amp_high_nxt = amp;
              if (amp < amp_low_r)  amp_low_nxt  = amp;
              // The time difference wraps with the millisecond timer.
              dt_nxt       = in_time_ms - prev_time_r;
              inc_pend_nxt = toggle_r;
              req.start    = 1'b1;
              st_nxt       = S_AMP;
            end else if (toggle_r) begin
              count_nxt = count_r + 1'b1;
            end
          end
        end
      end
      S_AMP: begin
        req.mean   = ivl_mean_r;
        req.addend = {dt_r, {IVL_FRAC{1'b0}}};
        if (rsp.done) begin
          amp_mean_nxt = rsp.quotient[AMP_W-1:0];
          req.start    = 1'b1;
          st_nxt       = S_INT;
        end
      end
      S_INT: begin
        if (rsp.done) begin
          ivl_mean_nxt = rsp.quotient;
          if (inc_pend_r) count_nxt = count_r + 1'b1;
          st_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          o_high_nxt     = high_r;
          o_low_nxt      = low_r;
          o_amp_mean_nxt = amp_mean_r;
          o_amp_high_nxt = amp_high_r;
          o_amp_low_nxt  = amp_low_r;
          o_ivl_mean_nxt = ivl_mean_r;
          o_total_nxt    = TOTAL_W'(count_r);
          o_fin_nxt      = fin_time_r;
          // Start a fresh measurement; the toggle and the previous extremum carry over.
          seen_any_nxt   = 1'b0;
          count_nxt      = '0;
          high_nxt       = HIGH_RST;
          low_nxt        = LOW_RST;
          amp_mean_nxt   = '0;
          amp_high_nxt   = '0;
          amp_low_nxt    = AMP_LOW_RST;
          ivl_mean_nxt   = '0;
          st_nxt         = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      seen_any_r   <= 1'b0;
      toggle_r     <= 1'b0;
      inc_pend_r   <= 1'b0;
      count_r      <= '0;
      prev_value_r <= '0;
      prev_time_r  <= '0;
      high_r       <= HIGH_RST;
      low_r        <= LOW_RST;
      amp_mean_r   <= '0;
      amp_high_r   <= '0;
      amp_low_r    <= AMP_LOW_RST;
      ivl_mean_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      seen_any_r   <= seen_any_nxt;
      toggle_r     <= toggle_nxt;
      inc_pend_r   <= inc_pend_nxt;
      count_r      <= count_nxt;
      prev_value_r <= prev_value_nxt;
      prev_time_r  <= prev_time_nxt;
      high_r       <= high_nxt;
      low_r        <= low_nxt;
      amp_mean_r   <= amp_mean_nxt;
      amp_high_r   <= amp_high_nxt;
      amp_low_r    <= amp_low_nxt;
      ivl_mean_r   <= ivl_mean_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    dt_r         <= dt_nxt;
    fin_time_r   <= fin_time_nxt;
    o_high_r     <= o_high_nxt;
    o_low_r      <= o_low_nxt;
    o_amp_mean_r <= o_amp_mean_nxt;
    o_amp_high_r <= o_amp_high_nxt;
    o_amp_low_r  <= o_amp_low_nxt;
    o_ivl_mean_r <= o_ivl_mean_nxt;
    o_total_r    <= o_total_nxt;
    o_fin_r      <= o_fin_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_peak_high          = o_high_r;
  assign out_peak_low           = o_low_r;
  assign out_mean_amplitude     = o_amp_mean_r;
  assign out_largest_amplitude  = o_amp_high_r;
  assign out_smallest_amplitude = o_amp_low_r;
  assign out_mean_interval      = o_ivl_mean_r;
  assign out_wave_total         = o_total_r;
  assign out_finish_time        = o_fin_r;

endmodule
